FILE: rtl/core/c2g_pkg.sv
package c2g_pkg;

    localparam int YEAR_W       = 12;
    localparam int Y_W          = 14;
    localparam int SOD_W        = 17;
    localparam int SUMA_W       = 22;
    localparam int SUM_W        = 23;
    localparam int U_W          = 21;
    localparam int Q_W          = 18;
    localparam int LEAP_W       = 6;

    localparam int YEAR_BIAS    = 4800;
    localparam int DAYS_YEAR    = 365;
    localparam int SEC_HOUR     = 3600;
    localparam int SEC_MINUTE   = 60;
    localparam int SEC_DAY      = 86400;
    localparam int SEC_WEEK     = 604800;
    localparam int LEAP_RESET   = 18;

    localparam int DIV25_MUL    = 2622;
    localparam int DIV25_SHIFT  = 16;
    localparam int DIV7_MUL     = 19173962;
    localparam int DIV7_SHIFT   = 27;

    localparam int WEEK_BIAS    = 110000;
    localparam int JDN_OFFSET   = 32045;
    localparam int GPS_EPOCH    = 2444245;
    localparam int DAY_BIAS     = JDN_OFFSET + GPS_EPOCH - 7 * WEEK_BIAS;
    localparam int TOW_MAX      = 6 * SEC_DAY + 31 * SEC_HOUR + 63 * SEC_MINUTE + 63;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_in_beat;

    typedef struct packed {
        logic [12:0] week_number;
        logic [19:0] time_of_week;
        logic [31:0] gps_seconds;
    } t_out_beat;

    function automatic logic [8:0] month_days(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            4'd12:   d = 9'd367;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/core/c2g_div7.sv
module c2g_div7 (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [c2g_pkg::U_W-1:0]  i_u,
    output logic [c2g_pkg::Q_W-1:0]  o_q,
    output logic [2:0]               o_rem
);

    localparam int PROD_W = c2g_pkg::U_W + 25;

    logic [PROD_W-1:0]          w_prod;
    logic [c2g_pkg::Q_W-1:0]    n_q;
    logic [c2g_pkg::Q_W-1:0]    r_q;
    logic [c2g_pkg::U_W-1:0]    r_u;

    assign w_prod = PROD_W'(i_u) * PROD_W'(c2g_pkg::DIV7_MUL);
    assign n_q    = w_prod[c2g_pkg::DIV7_SHIFT + c2g_pkg::Q_W - 1 : c2g_pkg::DIV7_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
            r_u <= i_u;
        end
    end

    // u - 7q equals u + q modulo 8
    assign o_q   = r_q;
    assign o_rem = 3'(r_u[2:0] + r_q[2:0]);

endmodule

FILE: rtl/core/calendar_to_gps_time_unit.sv
// Converts one UTC calendar epoch per beat into GPS week number, time of week
// and total GPS seconds (week * 604800 + time of week + leap_seconds). The
// pipeline has six register stages and the first one loads at the edge that
// takes the input beat; a result is offered by the last stage, and a new beat
// is taken every cycle while the output side keeps up; the stages stall
// together when the output register is full and not being taken.
// leap_seconds resets to 18 and is written through the configuration channel,
// which is always ready; write it only while the pipeline is empty.
module calendar_to_gps_time_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  c2g_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output c2g_pkg::t_out_beat  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [5:0]          i_cfg_data
);

    localparam int STAGES = 6;

    logic                               w_en;
    logic [STAGES-1:0]                  r_vld;
    logic [c2g_pkg::LEAP_W-1:0]         r_leap;

    logic                               w_early;
    logic [c2g_pkg::Y_W-1:0]            n_y;
    logic [3:0]                         n_m;
    logic [c2g_pkg::SOD_W-1:0]          n_sod;
    logic [c2g_pkg::Y_W-1:0]            r_y;
    logic [3:0]                         r_m;
    logic [4:0]                         r_dy;
    logic [c2g_pkg::SOD_W-1:0]          r_sod1;

    logic [11:0]                        w_q4;
    logic [23:0]                        w_prod_c;
    logic [c2g_pkg::SUMA_W-1:0]         n_suma;
    logic [c2g_pkg::SUMA_W-1:0]         r_suma;
    logic [11:0]                        r_q4;
    logic [7:0]                         r_c;
    logic [c2g_pkg::SOD_W-1:0]          r_sod2;

    logic [c2g_pkg::SUM_W-1:0]          w_sum;
    logic [c2g_pkg::U_W-1:0]            r_u;
    logic [c2g_pkg::SOD_W-1:0]          r_sod3;

    logic [c2g_pkg::Q_W-1:0]            w_q;
    logic [2:0]                         w_rem;
    logic [c2g_pkg::SOD_W-1:0]          r_sod4;

    logic [c2g_pkg::Q_W-1:0]            r_wk;
    logic [19:0]                        r_tow;

    logic [31:0]                        n_gps;
    c2g_pkg::t_out_beat                 r_out;

    assign w_en        = !r_vld[STAGES-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_vld[STAGES-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_leap <= c2g_pkg::LEAP_W'(c2g_pkg::LEAP_RESET);
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[STAGES-2:0], i_in_valid};
            end
            if (i_cfg_valid) begin
                r_leap <= i_cfg_data;
            end
        end
    end

    // January and February count as months 13 and 14 of the previous year
    assign w_early = i_in_data.month <= 4'd2;
    assign n_y     = c2g_pkg::Y_W'(i_in_data.year) + c2g_pkg::Y_W'(c2g_pkg::YEAR_BIAS)
                   - (w_early ? c2g_pkg::Y_W'(1) : c2g_pkg::Y_W'(0));
    assign n_m     = w_early ? 4'(i_in_data.month + 4'd9) : 4'(i_in_data.month - 4'd3);
    assign n_sod   = c2g_pkg::SOD_W'(i_in_data.hour) * c2g_pkg::SOD_W'(c2g_pkg::SEC_HOUR)
                   + c2g_pkg::SOD_W'(i_in_data.minute) * c2g_pkg::SOD_W'(c2g_pkg::SEC_MINUTE)
                   + c2g_pkg::SOD_W'(i_in_data.second);

    // y/100 = (y/4)/25, y/400 = (y/100)/4
    assign w_q4     = r_y[c2g_pkg::Y_W-1:2];
    assign w_prod_c = 24'(w_q4) * 24'(c2g_pkg::DIV25_MUL);
    assign n_suma   = c2g_pkg::SUMA_W'(r_y) * c2g_pkg::SUMA_W'(c2g_pkg::DAYS_YEAR)
                    + c2g_pkg::SUMA_W'(r_dy)
                    + c2g_pkg::SUMA_W'(c2g_pkg::month_days(r_m));

    // day count biased by whole weeks so it stays positive
    assign w_sum = c2g_pkg::SUM_W'(r_suma) + c2g_pkg::SUM_W'(r_q4) - c2g_pkg::SUM_W'(r_c)
                 + c2g_pkg::SUM_W'(r_c[7:2]) - c2g_pkg::SUM_W'(c2g_pkg::DAY_BIAS);

    assign n_gps = 32'({{(32 - c2g_pkg::Q_W){r_wk[c2g_pkg::Q_W-1]}}, r_wk})
                     * 32'(c2g_pkg::SEC_WEEK)
                 + 32'(r_tow) + 32'(r_leap);

    c2g_div7 u_div7 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_u   (r_u),
        .o_q   (w_q),
        .o_rem (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y    <= n_y;
            r_m    <= n_m;
            r_dy   <= i_in_data.day;
            r_sod1 <= n_sod;

            r_suma <= n_suma;
            r_q4   <= w_q4;
            r_c    <= w_prod_c[23:c2g_pkg::DIV25_SHIFT];
            r_sod2 <= r_sod1;

            r_u    <= w_sum[c2g_pkg::U_W-1:0];
            r_sod3 <= r_sod2;

            r_sod4 <= r_sod3;

            r_wk   <= w_q - c2g_pkg::Q_W'(c2g_pkg::WEEK_BIAS);
            r_tow  <= 20'(w_rem) * 20'(c2g_pkg::SEC_DAY) + 20'(r_sod4);

            r_out.week_number  <= r_wk[12:0];
            r_out.time_of_week <= r_tow;
            r_out.gps_seconds  <= n_gps;
        end
    end

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> w_rem != 3'd7)
        else $error("day remainder out of range");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_tow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.time_of_week <= 20'(c2g_pkg::TOW_MAX))
        else $error("time of week out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");

endmodule
